[rtl/core/gdc_pkg.sv]
// Package for the Gregorian date counter: word types, status codes,
// calendar tables and the control store of the step sequencer.
// No dependencies; every other file of the block imports it.
package gdc_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int WDAY_W = 3;
    localparam int DOY_W = 9;
    localparam int STAT_W = 2;
    localparam int SUM_W = 15;
    localparam int PROD_W = 31;
    localparam int PC_W = 4;

    localparam int DEF_EARLIEST_YEAR = 1753;
    localparam int DEF_LATEST_YEAR = 9999;

    // x / 25 == (x * RECIP25) >> 17 for x < 16384
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam int RECIP25_SH = 17;
    // x / 7 == (x * RECIP7) >> 18 for x < 32768
    localparam logic [15:0] RECIP7 = 16'd37450;
    localparam int RECIP7_SH = 18;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
    localparam logic [WDAY_W-1:0] WDAY_MON = 3'd1;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    typedef struct packed {
        logic               req_type;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
        logic [YEAR_W-1:0]  year_in;
    } t_in_word;

    typedef struct packed {
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic [YEAR_W-1:0]  year_out;
        logic [WDAY_W-1:0]  weekday;
        logic [DOY_W-1:0]   day_of_year;
        logic [STAT_W-1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_LEAPI,
        OP_PSUM,
        OP_MUL25,
        OP_Q100,
        OP_MUL7,
        OP_MOD7,
        OP_ADV,
        OP_BAD,
        OP_LEAPH,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_IS_ADV,
        C_NOT_OK,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic is_adv;
        logic not_ok;
        logic out_busy;
    } t_flags;

    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
    localparam logic [PC_W-1:0] PC_DISP = 4'd1;
    localparam logic [PC_W-1:0] PC_CHK = 4'd2;
    localparam logic [PC_W-1:0] PC_PSUM = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL25 = 4'd4;
    localparam logic [PC_W-1:0] PC_Q100 = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL7 = 4'd6;
    localparam logic [PC_W-1:0] PC_MOD7 = 4'd7;
    localparam logic [PC_W-1:0] PC_ADV = 4'd9;
    localparam logic [PC_W-1:0] PC_BAD = 4'd10;
    localparam logic [PC_W-1:0] PC_LEAPH = 4'd14;
    localparam logic [PC_W-1:0] PC_OUT = 4'd15;

    // Control store: jump to target when the condition holds, else step on.
    function automatic t_ucode ucode(input logic [PC_W-1:0] pc);
        t_ucode w;
        unique case (pc)
            PC_WAIT:  w = '{op: OP_LATCH, cond: C_NO_IN,    target: PC_WAIT};
            PC_DISP:  w = '{op: OP_LEAPI, cond: C_IS_ADV,   target: PC_ADV};
            PC_CHK:   w = '{op: OP_NOP,   cond: C_NOT_OK,   target: PC_BAD};
            PC_PSUM:  w = '{op: OP_PSUM,  cond: C_NEVER,    target: PC_WAIT};
            PC_MUL25: w = '{op: OP_MUL25, cond: C_NEVER,    target: PC_WAIT};
            PC_Q100:  w = '{op: OP_Q100,  cond: C_NEVER,    target: PC_WAIT};
            PC_MUL7:  w = '{op: OP_MUL7,  cond: C_NEVER,    target: PC_WAIT};
            PC_MOD7:  w = '{op: OP_MOD7,  cond: C_ALWAYS,   target: PC_LEAPH};
            PC_ADV:   w = '{op: OP_ADV,   cond: C_ALWAYS,   target: PC_LEAPH};
            PC_BAD:   w = '{op: OP_BAD,   cond: C_ALWAYS,   target: PC_LEAPH};
            PC_LEAPH: w = '{op: OP_LEAPH, cond: C_NEVER,    target: PC_WAIT};
            PC_OUT:   w = '{op: OP_OUT,   cond: C_OUT_BUSY, target: PC_OUT};
            default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2: d = leap ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] ordinal(input logic [MONTH_W-1:0] m,
                                                 input logic [DAY_W-1:0] d,
                                                 input logic leap);
        logic [DOY_W-1:0] n;
        n = days_before(m) + DOY_W'(d);
        if (leap && m > MON_FEB) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

[rtl/core/gregorian_date_counter.sv]
// Top level of the Gregorian date counter with weekday.
// Depends on gdc_pkg, gdc_seq and gdc_dpath.
//
// Input channel: i_in_valid / o_in_stall carry a t_in_word. A load word
// (req_type 0) checks and replaces the held date; an advance word
// (req_type 1) moves the held date on by one day (overflow on the last day).
// Output channel: o_out_valid / i_out_stall carry a t_out_word with the
// held date, weekday, day of year and status after each input word.
// Exactly one output word follows every input word, in order.
// A load steps through leap lookup, check, partial sum, multiply by 1/25,
// century correction, multiply by 1/7 and modulo 7 (weekday taken modulo
// 7 over the day count), then held leap flag and output; an advance jumps
// to its advance step, a rejected load to its invalid step, both then on
// to held leap flag and output. The next word is taken in the cycle after
// the output register is loaded; a word is not taken while one is in flight.
// The output register lets a new word be accepted while the previous
// result still waits; if it is still stalled when the next result is
// ready, the sequencer holds on the output step.
// Reset (synchronous, active low) sets the date to Monday, January 1 of
// the default earliest year and empties the output register.
module gregorian_date_counter #(
    parameter int EARLIEST_YEAR = gdc_pkg::DEF_EARLIEST_YEAR,
    parameter int LATEST_YEAR = gdc_pkg::DEF_LATEST_YEAR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gdc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gdc_pkg::t_out_word o_out_word
);
    import gdc_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;

    gdc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    gdc_dpath #(
        .EARLIEST_YEAR (EARLIEST_YEAR),
        .LATEST_YEAR   (LATEST_YEAR)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = (ctrl.op != OP_LATCH);

endmodule

[rtl/core/gdc_seq.sv]
// Step sequencer of the date counter: step counter, control store lookup
// and conditional jumps. Depends on gdc_pkg.
module gdc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  gdc_pkg::t_flags i_flags,
    output gdc_pkg::t_ctrl  o_ctrl
);
    import gdc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ucode          uc;
    logic            jump;

    assign uc = ucode(r_pc);

    always_comb begin
        unique case (uc.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !i_in_valid;
            C_IS_ADV:   jump = i_flags.is_adv;
            C_NOT_OK:   jump = i_flags.not_ok;
            C_OUT_BUSY: jump = i_flags.out_busy;
            default:    jump = 1'b1;
        endcase
        n_pc = jump ? uc.target : PC_W'(r_pc + 1'b1);
    end

    always_comb begin
        o_ctrl.op = uc.op;
        o_ctrl.fire = !jump || (uc.cond == C_ALWAYS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/core/gdc_dpath.sv]
// Datapath of the date counter: held date, weekday arithmetic, leap unit
// and output register, steered by the sequencer's control word. Depends on gdc_pkg.
module gdc_dpath #(
    parameter int EARLIEST_YEAR = gdc_pkg::DEF_EARLIEST_YEAR,
    parameter int LATEST_YEAR = gdc_pkg::DEF_LATEST_YEAR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gdc_pkg::t_ctrl     i_ctrl,
    input  gdc_pkg::t_in_word  i_in_word,
    input  logic               i_out_stall,
    output gdc_pkg::t_flags    o_flags,
    output logic               o_out_valid,
    output gdc_pkg::t_out_word o_out_word
);
    import gdc_pkg::*;

    t_in_word           r_in;
    logic               r_in_leap;
    logic [SUM_W-1:0]   r_sum;
    logic [PROD_W-1:0]  r_prod;
    logic [STAT_W-1:0]  r_status;
    t_out_word          r_out;

    logic [MONTH_W-1:0] r_held_month, n_held_month;
    logic [DAY_W-1:0]   r_held_day, n_held_day;
    logic [YEAR_W-1:0]  r_held_year, n_held_year;
    logic [WDAY_W-1:0]  r_held_wd, n_held_wd;
    logic               r_held_leap, n_held_leap;
    logic               r_out_valid, n_out_valid;

    logic [YEAR_W-1:0]  p;
    logic [YEAR_W-3:0]  p4;
    logic [DOY_W-1:0]   ord_in;
    logic [24:0]        m25;
    logic [7:0]         q100;
    logic [12:0]        q7;
    logic [SUM_W-1:0]   q7x7;
    logic [SUM_W-1:0]   wd_full;

    logic [YEAR_W-1:0]  ly;
    logic [26:0]        lprod;
    logic [9:0]         q25;
    logic [YEAR_W-1:0]  q25x25;
    logic               leap_val;

    logic [DAY_W-1:0]   last_day;
    logic               adv_ovf;
    logic [WDAY_W-1:0]  wd_inc;
    logic               load_ok;

    assign p = r_in.year_in - YEAR_W'(1);
    assign p4 = p[YEAR_W-1:2];
    assign ord_in = ordinal(r_in.month_in, r_in.day_in, r_in_leap);
    assign m25 = 25'(p4) * 25'(RECIP25);
    assign q100 = r_prod[RECIP25_SH+7:RECIP25_SH];
    assign q7 = r_prod[RECIP7_SH+12:RECIP7_SH];
    assign q7x7 = SUM_W'({q7, 3'b000}) - SUM_W'(q7);
    assign wd_full = r_sum - q7x7;

    assign ly = (i_ctrl.op == OP_LEAPH) ? r_held_year : r_in.year_in;
    assign lprod = 27'(ly) * 27'(RECIP25);
    assign q25 = lprod[RECIP25_SH+9:RECIP25_SH];
    assign q25x25 = YEAR_W'({q25, 4'b0000}) + YEAR_W'({q25, 3'b000}) + YEAR_W'(q25);
    assign leap_val = (ly[1:0] == 2'b00) && ((q25x25 != ly) || (q25[3:0] == 4'd0));

    assign last_day = month_days(r_held_month, r_held_leap);
    assign adv_ovf = (r_held_day >= last_day) && (r_held_month >= MON_DEC) &&
                     (r_held_year >= YEAR_W'(LATEST_YEAR));
    assign wd_inc = (r_held_wd >= WDAY_SAT) ? '0 : WDAY_W'(r_held_wd + 1'b1);

    assign load_ok = (r_in.month_in >= MON_JAN) && (r_in.month_in <= MON_DEC) &&
                     (r_in.year_in >= YEAR_W'(EARLIEST_YEAR)) &&
                     (r_in.year_in <= YEAR_W'(LATEST_YEAR)) &&
                     (r_in.day_in != '0) &&
                     (r_in.day_in <= month_days(r_in.month_in, r_in_leap));

    always_comb begin
        o_flags.is_adv = (r_in.req_type == REQ_ADVANCE);
        o_flags.not_ok = !load_ok;
        o_flags.out_busy = r_out_valid && i_out_stall;
    end

    always_comb begin
        n_held_month = r_held_month;
        n_held_day = r_held_day;
        n_held_year = r_held_year;
        n_held_wd = r_held_wd;
        n_held_leap = r_held_leap;
        case (i_ctrl.op)
            OP_MOD7: begin
                n_held_month = r_in.month_in;
                n_held_day = r_in.day_in;
                n_held_year = r_in.year_in;
                n_held_wd = wd_full[WDAY_W-1:0];
            end
            OP_ADV: begin
                if (r_held_day < last_day) begin
                    n_held_day = DAY_W'(r_held_day + 1'b1);
                    n_held_wd = wd_inc;
                end else if (r_held_month < MON_DEC) begin
                    n_held_month = MONTH_W'(r_held_month + 1'b1);
                    n_held_day = 5'd1;
                    n_held_wd = wd_inc;
                end else if (!adv_ovf) begin
                    n_held_year = YEAR_W'(r_held_year + 1'b1);
                    n_held_month = MON_JAN;
                    n_held_day = 5'd1;
                    n_held_wd = wd_inc;
                end
            end
            OP_LEAPH: n_held_leap = leap_val;
            default: ;
        endcase
    end

    always_comb begin
        if (i_ctrl.op == OP_OUT && i_ctrl.fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_month <= MON_JAN;
            r_held_day <= 5'd1;
            r_held_year <= YEAR_W'(DEF_EARLIEST_YEAR);
            r_held_wd <= WDAY_MON;
            r_held_leap <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_held_month <= n_held_month;
            r_held_day <= n_held_day;
            r_held_year <= n_held_year;
            r_held_wd <= n_held_wd;
            r_held_leap <= n_held_leap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LATCH: begin
                if (i_ctrl.fire) begin
                    r_in <= i_in_word;
                end
            end
            OP_LEAPI: r_in_leap <= leap_val;
            OP_PSUM:  r_sum <= SUM_W'(p) + SUM_W'(p4) + SUM_W'(ord_in);
            OP_MUL25: r_prod <= PROD_W'(m25);
            OP_Q100:  r_sum <= r_sum - SUM_W'(q100) + SUM_W'(q100[7:2]);
            OP_MUL7:  r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP7);
            OP_MOD7:  r_status <= ST_OK;
            OP_ADV:   r_status <= adv_ovf ? ST_OVERFLOW : ST_OK;
            OP_BAD:   r_status <= ST_INVALID;
            OP_OUT: begin
                if (i_ctrl.fire) begin
                    r_out.month_out <= r_held_month;
                    r_out.day_out <= r_held_day;
                    r_out.year_out <= r_held_year;
                    r_out.weekday <= r_held_wd;
                    r_out.day_of_year <= ordinal(r_held_month, r_held_day, r_held_leap);
                    r_out.status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out;

endmodule

[rtl/core/gdc_checker.sv]
// Port-level checks for the Gregorian date counter, bound to the top level.
// Depends on gdc_pkg and gregorian_date_counter.
module gdc_checker #(
    parameter int LATEST_YEAR = gdc_pkg::DEF_LATEST_YEAR
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gdc_pkg::t_out_word o_out_word
);
    import gdc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed or dropped");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.status != 2'd3) && (o_out_word.weekday <= WDAY_SAT) &&
        (o_out_word.day_of_year != 9'd0) && (o_out_word.day_of_year <= 9'd366))
        else $error("output word field out of range");

    a_overflow_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_OVERFLOW) |->
        (o_out_word.month_out == MON_DEC) && (o_out_word.day_out == 5'd31) &&
        (o_out_word.year_out == YEAR_W'(LATEST_YEAR)))
        else $error("overflow reported away from the last day");

endmodule

bind gregorian_date_counter gdc_checker #(
    .LATEST_YEAR (LATEST_YEAR)
) u_gdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Testbench for gregorian_date_counter: directed table, then random words over three
// idle/stall phases. Output is checked against typed rows or a calendar predictor.
// Depends on gdc_pkg and the gregorian_date_counter RTL.
module testbench;
    import gdc_pkg::*;

    localparam int FIRST_YEAR = DEF_EARLIEST_YEAR;
    localparam int LAST_YEAR = DEF_LATEST_YEAR;
    localparam int RANDOM_WORDS = 1500;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        t_in_word  stim;
        logic      typed;
        t_out_word want;
    } t_step_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    int unsigned cal_month = 32'(MON_JAN);
    int unsigned cal_day = 1;
    int unsigned cal_year = FIRST_YEAR;
    int unsigned cal_wday = 32'(WDAY_MON);

    t_out_word   date_q[$];
    int          fail_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int unsigned cycle_count = 0;

    gregorian_date_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11: n = 30;
            32'(MON_FEB): n = is_leap(y) ? 29 : 28;
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic int unsigned day_number(input int unsigned m, input int unsigned d,
                                               input int unsigned y);
        int unsigned n;
        n = d;
        for (int unsigned k = 32'(MON_JAN); k < m; k++) begin
            n += days_in(k, y);
        end
        return n;
    endfunction

    // Day count since January 1 of year 1 (a Monday) modulo 7.
    function automatic int unsigned weekday_of(input int unsigned m, input int unsigned d,
                                               input int unsigned y);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + day_number(m, d, y);
        return n % 7;
    endfunction

    function automatic t_out_word predict_date(input t_in_word w);
        t_out_word   r;
        logic [STAT_W-1:0] st;
        int unsigned m;
        int unsigned d;
        int unsigned y;
        st = ST_OK;
        if (w.req_type == REQ_LOAD) begin
            m = 32'(w.month_in);
            d = 32'(w.day_in);
            y = 32'(w.year_in);
            if (m >= MON_JAN && m <= MON_DEC && y >= FIRST_YEAR && y <= LAST_YEAR &&
                d >= 1 && d <= days_in(m, y)) begin
                cal_month = m;
                cal_day = d;
                cal_year = y;
                cal_wday = weekday_of(m, d, y);
            end else begin
                st = ST_INVALID;
            end
        end else if (cal_day < days_in(cal_month, cal_year)) begin
            cal_day++;
            cal_wday = (cal_wday + 1) % 7;
        end else if (cal_month < MON_DEC) begin
            cal_month++;
            cal_day = 1;
            cal_wday = (cal_wday + 1) % 7;
        end else if (cal_year < LAST_YEAR) begin
            cal_year++;
            cal_month = 32'(MON_JAN);
            cal_day = 1;
            cal_wday = (cal_wday + 1) % 7;
        end else begin
            st = ST_OVERFLOW;
        end
        r.month_out = MONTH_W'(cal_month);
        r.day_out = DAY_W'(cal_day);
        r.year_out = YEAR_W'(cal_year);
        r.weekday = WDAY_W'(cal_wday);
        r.day_of_year = DOY_W'(day_number(cal_month, cal_day, cal_year));
        r.status = st;
        return r;
    endfunction

    function automatic t_out_word out_of(input int m, input int d, input int y, input int wd,
                                         input int doy, input logic [STAT_W-1:0] st);
        t_out_word r;
        r.month_out = MONTH_W'(m);
        r.day_out = DAY_W'(d);
        r.year_out = YEAR_W'(y);
        r.weekday = WDAY_W'(wd);
        r.day_of_year = DOY_W'(doy);
        r.status = st;
        return r;
    endfunction

    function automatic t_step_row row(input logic req, input int m, input int d, input int y,
                                      input logic typed, input t_out_word want);
        t_step_row r;
        r.stim.req_type = req;
        r.stim.month_in = MONTH_W'(m);
        r.stim.day_in = DAY_W'(d);
        r.stim.year_in = YEAR_W'(y);
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word    w;
        int unsigned pick;
        int unsigned sel;
        int unsigned y;
        int unsigned m;
        int unsigned last;
        w.req_type = REQ_LOAD;
        w.month_in = MONTH_W'($urandom);
        w.day_in = DAY_W'($urandom);
        w.year_in = YEAR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            w.req_type = REQ_ADVANCE;
        end else if (pick < 80) begin
            sel = $urandom_range(9);
            if (sel < 4) y = $urandom_range(FIRST_YEAR, 2100);
            else if (sel == 4) y = 100 * $urandom_range(18, 24);
            else if (sel == 5) y = 4 * $urandom_range(439, 524);
            else if (sel < 8) y = $urandom_range(FIRST_YEAR, LAST_YEAR);
            else y = $urandom_range(LAST_YEAR - 3, LAST_YEAR);
            m = $urandom_range(MON_JAN, MON_DEC);
            last = days_in(m, y);
            w.month_in = MONTH_W'(m);
            w.year_in = YEAR_W'(y);
            w.day_in = DAY_W'($urandom_range(1) ? $urandom_range(last - 2, last)
                                                : $urandom_range(1, last));
        end else if (pick < 86) begin
            w.month_in = MON_DEC;
            w.day_in = DAY_W'($urandom_range(29, 31));
            w.year_in = YEAR_W'(LAST_YEAR);
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input logic typed, input t_out_word want);
        t_out_word pred;
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = predict_date(w);
        date_q.push_back(typed ? want : pred);
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word exp_word;
        if (date_q.size() == 0) begin
            if (fail_count < 10) $display("unexpected output word %h", got);
            fail_count++;
        end else begin
            exp_word = date_q.pop_front();
            if (got.month_out !== exp_word.month_out || got.day_out !== exp_word.day_out ||
                got.year_out !== exp_word.year_out || got.weekday !== exp_word.weekday ||
                got.day_of_year !== exp_word.day_of_year || got.status !== exp_word.status) begin
                if (fail_count < 10) begin
                    $display("mismatch exp %0d/%0d/%0d wd %0d doy %0d st %0d",
                             exp_word.month_out, exp_word.day_out, exp_word.year_out,
                             exp_word.weekday, exp_word.day_of_year, exp_word.status);
                    $display("         got %0d/%0d/%0d wd %0d doy %0d st %0d",
                             got.month_out, got.day_out, got.year_out,
                             got.weekday, got.day_of_year, got.status);
                end
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_word(o_out_word);
        end
        i_out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gregorian_date_counter verification failed");
            $finish;
        end
    end

    initial begin
        t_step_row rows[$];
        t_out_word held;
        held = out_of(MON_JAN, 2, FIRST_YEAR, 2, 2, ST_INVALID);
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b1, out_of(MON_JAN, 2, FIRST_YEAR, 2, 2, ST_OK)));
        rows.push_back(row(REQ_LOAD, 0, 1, 2000, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 13, 1, 2000, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 15, 31, 16383, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 1, 0, 2000, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 1, 1, FIRST_YEAR - 1, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 1, 1, LAST_YEAR + 1, 1'b1, held));
        rows.push_back(row(REQ_LOAD, MON_FEB, 29, 1900, 1'b1, held));
        rows.push_back(row(REQ_LOAD, 4, 31, 2023, 1'b1, held));
        rows.push_back(row(REQ_LOAD, MON_JAN, 1, FIRST_YEAR, 1'b1,
                           out_of(MON_JAN, 1, FIRST_YEAR, WDAY_MON, 1, ST_OK)));
        rows.push_back(row(REQ_LOAD, MON_FEB, 28, 2024, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 15, 31, 16383, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, MON_FEB, 29, 2000, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, MON_FEB, 28, 2100, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, MON_DEC, 31, 2023, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, MON_DEC, 31, 2000, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, 4, 30, 2023, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, MON_DEC, 31, LAST_YEAR, 1'b0, '0));
        rows.push_back(row(REQ_ADVANCE, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(REQ_LOAD, 0, 0, 0, 1'b0, '0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 34;
        recv_idle = 55;

        foreach (rows[k]) begin
            send_word(rows[k].stim, rows[k].typed, rows[k].want);
        end
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS / 3) begin
                send_idle = 55;
                recv_idle = 34;
            end else if (k == 2 * RANDOM_WORDS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_word(rand_word(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (date_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("gregorian_date_counter verification clean");
        end else begin
            $display("gregorian_date_counter verification failed");
        end
        $finish;
    end

endmodule
